FILE: sv/qph_pkg.sv
// qph_pkg: shared types and codes for the quadratic probe hash table
// request and response structs, mode, slot state and status codes
// no dependencies
package qph_pkg;

	// request and response items as seen on the top-level ports
	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] key_hash;
		logic [31:0] key;
		logic [31:0] value_in;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] value_out;
		logic [7:0]  slot_index;
		logic [8:0]  entry_count;
	} rsp_t;

	// request modes
	localparam logic [1:0] MODE_LOOKUP = 2'd0;
	localparam logic [1:0] MODE_INSERT = 2'd1;
	localparam logic [1:0] MODE_REMOVE = 2'd2;
	localparam logic [1:0] MODE_UPDATE = 2'd3;

	// per-slot states
	localparam logic [1:0] SLOT_EMPTY   = 2'd0;
	localparam logic [1:0] SLOT_DELETED = 2'd1;
	localparam logic [1:0] SLOT_ACTIVE  = 2'd2;
	localparam logic [1:0] SLOT_MASK    = 2'h3;

	// response status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// hash reduction: reciprocal multiply, remainder, correction
	localparam int HASH_BITS = 32;
	localparam int RED_STEPS = 3;

endpackage

FILE: sv/qph_front.sv
// qph_front: accepts one item, reduces its hash modulo the slot count with a
// reciprocal multiply and one correction, then hands it to the queue; uses qph_pkg
module qph_front #(
	parameter int CAPACITY = 256,
	parameter int KEY_W    = 32,
	parameter int VAL_W    = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  qph_pkg::req_t                req,
	output logic                         occupied,
	output logic                         q_valid,
	input  logic                         q_ready,
	output logic [1:0]                   q_mode,
	output logic [$clog2(CAPACITY)-1:0]  q_slot,
	output logic [KEY_W-1:0]             q_key,
	output logic [VAL_W-1:0]             q_val
);
	import qph_pkg::*;

	localparam int IW    = $clog2(CAPACITY);
	localparam int SH    = HASH_BITS + IW;
	localparam int PW    = 2 * HASH_BITS + 1;
	localparam int CNT_W = $clog2(RED_STEPS);
	// floor(2^SH / CAPACITY): the quotient estimate is exact or one short
	localparam logic [HASH_BITS:0] RECIP = (HASH_BITS+1)'((64'd1 << SH) / 64'(CAPACITY));
	localparam logic [IW:0]        CAP_W = (IW+1)'(CAPACITY);

	logic                 full_q;
	logic                 red_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [HASH_BITS-1:0] hash_q;
	logic [IW:0]          qlo_q;
	logic [IW:0]          part_q;
	logic [IW-1:0]        rem_q;
	logic [1:0]           mode_q;
	logic [KEY_W-1:0]     key_q;
	logic [VAL_W-1:0]     val_q;
	logic [IW:0]          part_d;
	logic [IW-1:0]        rem_d;
	logic                 accept;

	assign accept   = start && !full_q;
	assign occupied = full_q;
	assign q_valid  = full_q && !red_q;
	assign q_mode   = mode_q;
	assign q_slot   = rem_q;
	assign q_key    = key_q;
	assign q_val    = val_q;

	// hash - q * CAPACITY lies below twice the capacity, so its low bits suffice;
	// one conditional subtract brings it into range
	always_comb begin
		logic [IW:0] qc_lo;
		logic [IW:0] less_cap;
		qc_lo    = qlo_q * CAP_W;
		part_d   = hash_q[IW:0] - qc_lo;
		less_cap = part_q - CAP_W;
		rem_d    = (part_q >= CAP_W) ? less_cap[IW-1:0] : part_q[IW-1:0];
	end

	// control: item held, reduction running, step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			red_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (accept) begin
				full_q <= 1'b1;
				red_q  <= 1'b1;
				cnt_q  <= '0;
			end else if (red_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(RED_STEPS - 1)) begin
					red_q <= 1'b0;
				end
			end else if (q_valid && q_ready) begin
				full_q <= 1'b0;
			end
		end
	end

	// payload of the held item; the reduction registers settle one per step
	always_ff @(posedge clk) begin
		if (accept) begin
			hash_q <= req.key_hash;
			mode_q <= req.mode;
			key_q  <= KEY_W'(req.key);
			val_q  <= VAL_W'(req.value_in);
		end else if (red_q) begin
			qlo_q  <= (IW+1)'((PW'(hash_q) * PW'(RECIP)) >> SH);
			part_q <= part_d;
			rem_q  <= rem_d;
		end
	end

endmodule

FILE: sv/qph_fifo.sv
// qph_fifo: two-entry queue between the front and the probe engine
// head and tail registers with valid bits; no package use
module qph_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         ready,
	input  logic         pop,
	output logic         valid,
	output logic [W-1:0] dout
);
	logic         head_v_q;
	logic         tail_v_q;
	logic [W-1:0] head_q;
	logic [W-1:0] tail_q;
	logic         do_push;
	logic         do_pop;

	assign ready   = !tail_v_q;
	assign valid   = head_v_q;
	assign dout    = head_q;
	assign do_push = push && !tail_v_q;
	assign do_pop  = pop && head_v_q;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			tail_v_q <= 1'b0;
		end else begin
			case ({do_push, do_pop})
				2'b10: begin
					if (head_v_q) begin
						tail_v_q <= 1'b1;
					end else begin
						head_v_q <= 1'b1;
					end
				end
				2'b01: begin
					head_v_q <= tail_v_q;
					tail_v_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// entry data moves towards the head
	always_ff @(posedge clk) begin
		case ({do_push, do_pop})
			2'b10: begin
				if (head_v_q) begin
					tail_q <= din;
				end else begin
					head_q <= din;
				end
			end
			2'b01: begin
				head_q <= tail_q;
			end
			2'b11: begin
				if (tail_v_q) begin
					head_q <= tail_q;
					tail_q <= din;
				end else begin
					head_q <= din;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: sv/qph_back.sv
// qph_back: probe engine with the slot state, key and value memories
// clears slot states after reset, probes one slot per cycle; uses qph_pkg
module qph_back #(
	parameter int CAPACITY = 256,
	parameter int KEY_W    = 32,
	parameter int VAL_W    = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	output logic                         clearing,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  logic [1:0]                   item_mode,
	input  logic [$clog2(CAPACITY)-1:0]  item_slot,
	input  logic [KEY_W-1:0]             item_key,
	input  logic [VAL_W-1:0]             item_val,
	output logic                         done,
	output qph_pkg::rsp_t                rsp
);
	import qph_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		S_CLEAR = 3'b001,
		S_IDLE  = 3'b010,
		S_PROBE = 3'b100
	} state_t;

	state_t        state_q;
	logic [IW-1:0] clr_q;
	logic [IW-1:0] cur_q;
	logic [IW-1:0] inc_q;
	logic [IW-1:0] step_q;
	logic [CW-1:0] count_q;
	logic          done_q;
	rsp_t          rsp_q;
	logic [1:0]    mode_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;

	// slot memories, read data registered
	logic [1:0]       st_mem  [CAPACITY];
	logic [KEY_W-1:0] key_mem [CAPACITY];
	logic [VAL_W-1:0] val_mem [CAPACITY];
	logic [1:0]       st_rd;
	logic [KEY_W-1:0] key_rd;
	logic [VAL_W-1:0] val_rd;

	logic [IW-1:0] rd_addr;
	logic [IW-1:0] next_slot;
	logic [IW-1:0] next_inc;
	logic          take;
	logic          fin;
	logic          hit;
	logic [1:0]    status_d;
	logic [CW-1:0] count_d;
	logic          st_we;
	logic [IW-1:0] st_wa;
	logic [1:0]    st_wd;
	logic          key_we;
	logic          val_we;

	assign clearing   = (state_q == S_CLEAR);
	assign item_ready = (state_q == S_IDLE);
	assign take       = item_valid && item_ready;
	assign done       = done_q;
	assign rsp        = rsp_q;

	// next probe: slot advances by 2i+1 and the increment by two, both kept below capacity
	always_comb begin
		logic [IW:0] s;
		logic [IW:0] n;
		s = {1'b0, cur_q} + {1'b0, inc_q};
		if (s >= (IW+1)'(CAPACITY)) begin
			s = s - (IW+1)'(CAPACITY);
		end
		n = {1'b0, inc_q} + (IW+1)'(2);
		if (n >= (IW+1)'(CAPACITY)) begin
			n = n - (IW+1)'(CAPACITY);
		end
		next_slot = s[IW-1:0];
		next_inc  = n[IW-1:0];
	end

	// read address: head of the queue when idle, the next probe while probing, the clear pointer while clearing
	always_comb begin
		unique case (state_q)
			S_IDLE:  rd_addr = item_slot;
			S_PROBE: rd_addr = next_slot;
			S_CLEAR: rd_addr = clr_q;
			default: rd_addr = cur_q;
		endcase
	end

	// classify the slot just read against the item's mode
	always_comb begin
		logic [1:0] st;
		logic       active;
		logic       empty;
		logic       match;
		logic       last;
		st       = st_rd & SLOT_MASK;
		active   = (st == SLOT_ACTIVE);
		empty    = (st == SLOT_EMPTY);
		match    = active && (key_rd == key_q);
		last     = (step_q == IW'(CAPACITY - 1));
		fin      = 1'b0;
		hit      = 1'b0;
		status_d = ST_MISS;
		unique case (mode_q) inside
			MODE_LOOKUP: begin
				if (match) begin
					fin      = 1'b1;
					hit      = 1'b1;
					status_d = ST_OK;
				end else if (empty || last) begin
					fin = 1'b1;
				end
			end
			MODE_INSERT: begin
				if (!active) begin
					fin      = 1'b1;
					hit      = 1'b1;
					status_d = ST_OK;
				end else if (last) begin
					fin      = 1'b1;
					status_d = ST_FULL;
				end
			end
			MODE_REMOVE, MODE_UPDATE: begin
				if (match) begin
					fin      = 1'b1;
					hit      = 1'b1;
					status_d = ST_OK;
				end else if (last) begin
					fin = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// memory write controls and the active count after this item
	always_comb begin
		logic commit;
		commit  = (state_q == S_PROBE) && fin && hit;
		st_we   = clearing;
		st_wa   = clr_q;
		st_wd   = SLOT_EMPTY;
		key_we  = 1'b0;
		val_we  = 1'b0;
		count_d = count_q;
		if (commit && (mode_q == MODE_INSERT)) begin
			st_we   = 1'b1;
			st_wa   = cur_q;
			st_wd   = SLOT_ACTIVE;
			key_we  = 1'b1;
			val_we  = 1'b1;
			count_d = count_q + CW'(1);
		end else if (commit && (mode_q == MODE_REMOVE)) begin
			st_we = 1'b1;
			st_wa = cur_q;
			st_wd = SLOT_DELETED;
			if (count_q != '0) begin
				count_d = count_q - CW'(1);
			end
		end else if (commit && (mode_q == MODE_UPDATE)) begin
			val_we = 1'b1;
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (st_we) begin
			st_mem[st_wa] <= st_wd;
		end
		if (key_we) begin
			key_mem[cur_q] <= key_q;
		end
		if (val_we) begin
			val_mem[cur_q] <= val_q;
		end
		st_rd  <= st_mem[rd_addr];
		key_rd <= key_mem[rd_addr];
		val_rd <= val_mem[rd_addr];
	end

	// sequencer: clearing pass, wait for an item, probe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == IW'(CAPACITY - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (take) begin
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (fin) begin
						state_q <= S_IDLE;
						count_q <= count_d;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// probe position and the item under work
	always_ff @(posedge clk) begin
		if (take) begin
			cur_q  <= item_slot;
			inc_q  <= IW'(1);
			step_q <= '0;
			mode_q <= item_mode;
			key_q  <= item_key;
			val_q  <= item_val;
		end else if (state_q == S_PROBE) begin
			cur_q  <= next_slot;
			inc_q  <= next_inc;
			step_q <= step_q + IW'(1);
		end
	end

	// response register
	always_ff @(posedge clk) begin
		if ((state_q == S_PROBE) && fin) begin
			rsp_q.status      <= status_d;
			rsp_q.value_out   <= (hit && (mode_q == MODE_LOOKUP)) ? 32'(val_rd) : '0;
			rsp_q.slot_index  <= hit ? 8'(cur_q) : '0;
			rsp_q.entry_count <= 9'(count_d);
		end
	end

endmodule

FILE: sv/quadratic_probe_hash_table.sv
// Quadratic probe hash table. An item (mode, key hash, key, value) is taken
// when start is high and busy is low. The front reduces the hash modulo
// CAPACITY with a reciprocal multiply and a correction and passes the item
// through a two-entry queue to the probe engine; the front takes no new
// item until the last one has entered the queue. The probe engine reads
// one slot per cycle from its slot memories: an item is taken in the idle
// state and then probes from one up to CAPACITY slots, the chain length
// being set by occupancy and mode.
// Each result appears on rsp for exactly one cycle with done high; the
// receiver cannot stall it. After reset the slot states are cleared in a
// pass over all CAPACITY slots, during which busy is high.

// top level: front, queue and probe engine; depends on qph_pkg,
// qph_front, qph_fifo and qph_back
module quadratic_probe_hash_table #(
	parameter int CAPACITY   = 256,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  qph_pkg::req_t req,
	output logic          busy,
	output logic          done,
	output qph_pkg::rsp_t rsp
);
	import qph_pkg::*;

	localparam int IW    = $clog2(CAPACITY);
	localparam int KEY_W = (KEY_BITS < 32) ? KEY_BITS : 32;
	localparam int VAL_W = (VALUE_BITS < 32) ? VALUE_BITS : 32;
	localparam int QW    = 2 + IW + KEY_W + VAL_W;

	logic             occupied;
	logic             clearing;
	logic             f_valid;
	logic             f_ready;
	logic [1:0]       f_mode;
	logic [IW-1:0]    f_slot;
	logic [KEY_W-1:0] f_key;
	logic [VAL_W-1:0] f_val;
	logic             h_valid;
	logic             h_ready;
	logic [QW-1:0]    h_data;
	logic [1:0]       h_mode;
	logic [IW-1:0]    h_slot;
	logic [KEY_W-1:0] h_key;
	logic [VAL_W-1:0] h_val;

	assign busy = occupied || clearing;
	assign {h_mode, h_slot, h_key, h_val} = h_data;

	qph_front #(
		.CAPACITY (CAPACITY),
		.KEY_W    (KEY_W),
		.VAL_W    (VAL_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start && !clearing),
		.req      (req),
		.occupied (occupied),
		.q_valid  (f_valid),
		.q_ready  (f_ready),
		.q_mode   (f_mode),
		.q_slot   (f_slot),
		.q_key    (f_key),
		.q_val    (f_val)
	);

	qph_fifo #(
		.W (QW)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_valid),
		.din    ({f_mode, f_slot, f_key, f_val}),
		.ready  (f_ready),
		.pop    (h_ready),
		.valid  (h_valid),
		.dout   (h_data)
	);

	qph_back #(
		.CAPACITY (CAPACITY),
		.KEY_W    (KEY_W),
		.VAL_W    (VAL_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.clearing   (clearing),
		.item_valid (h_valid),
		.item_ready (h_ready),
		.item_mode  (h_mode),
		.item_slot  (h_slot),
		.item_key   (h_key),
		.item_val   (h_val),
		.done       (done),
		.rsp        (rsp)
	);

	// an accepted item keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block not busy after accepting an item");

	// a miss or a full table reports no slot and no value
	a_miss_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.status != ST_OK) |-> (rsp.slot_index == '0) && (rsp.value_out == '0))
		else $error("slot or value reported without a hit");

	// results never come in consecutive cycles
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("results in consecutive cycles");

	// no result while the slot states are being cleared
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !done)
		else $error("result during clearing pass");

endmodule

FILE: dv/tb_quadratic_probe_hash_table.sv
// tb_quadratic_probe_hash_table: self-checking bench for the quadratic probe hash table
// keeps a shadow table that predicts every response and compares it field by field
// depends on qph_pkg and quadratic_probe_hash_table
`timescale 1ns / 1ps

module tb_quadratic_probe_hash_table;
	import qph_pkg::*;

	localparam int SLOTS       = 256;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int TAIL_CYCLES = 300;
	localparam int POOL_DEPTH  = 96;

	// shadow of the table: predicts each response from the requests taken so far
	class probe_table_model;
		logic [1:0]  slot_st [SLOTS];
		logic [31:0] key_mem [SLOTS];
		logic [31:0] val_mem [SLOTS];
		int unsigned live_entries;
		rsp_t        awaited_results[$];
		int unsigned error_count;

		function new();
			foreach (slot_st[i]) begin
				slot_st[i] = SLOT_EMPTY;
				key_mem[i] = '0;
				val_mem[i] = '0;
			end
			live_entries = 0;
			error_count  = 0;
		endfunction

		function logic [7:0] probe_slot(logic [31:0] h, int unsigned step);
			longint unsigned s;
			s = h;
			s = s + longint'(step) * longint'(step);
			return 8'(s % SLOTS);
		endfunction

		// first active slot holding the key, optionally giving up at an empty slot
		function bit find_key(logic [31:0] h, logic [31:0] k, bit stop_at_empty,
				output logic [7:0] where);
			logic [7:0] ix;
			where = '0;
			for (int i = 0; i < SLOTS; i++) begin
				ix = probe_slot(h, i);
				if (slot_st[ix] == SLOT_ACTIVE && key_mem[ix] == k) begin
					where = ix;
					return 1'b1;
				end
				if (stop_at_empty && slot_st[ix] == SLOT_EMPTY)
					return 1'b0;
			end
			return 1'b0;
		endfunction

		// work out the response to an accepted item and update the shadow
		function void note_request(req_t r);
			rsp_t       exp;
			logic [7:0] ix;
			bit         found;
			exp        = '0;
			exp.status = ST_MISS;
			found      = 1'b0;
			case (r.mode)
				MODE_LOOKUP: begin
					if (find_key(r.key_hash, r.key, 1'b1, ix)) begin
						exp.status     = ST_OK;
						exp.value_out  = val_mem[ix];
						exp.slot_index = ix;
					end
				end
				MODE_INSERT: begin
					for (int i = 0; i < SLOTS && !found; i++) begin
						ix = probe_slot(r.key_hash, i);
						if (slot_st[ix] != SLOT_ACTIVE)
							found = 1'b1;
					end
					if (found) begin
						slot_st[ix]    = SLOT_ACTIVE;
						key_mem[ix]    = r.key;
						val_mem[ix]    = r.value_in;
						live_entries++;
						exp.status     = ST_OK;
						exp.slot_index = ix;
					end else begin
						exp.status = ST_FULL;
					end
				end
				MODE_REMOVE: begin
					if (find_key(r.key_hash, r.key, 1'b0, ix)) begin
						slot_st[ix] = SLOT_DELETED;
						if (live_entries > 0)
							live_entries--;
						exp.status     = ST_OK;
						exp.slot_index = ix;
					end
				end
				default: begin
					if (find_key(r.key_hash, r.key, 1'b0, ix)) begin
						val_mem[ix]    = r.value_in;
						exp.status     = ST_OK;
						exp.slot_index = ix;
					end
				end
			endcase
			exp.entry_count = 9'(live_entries);
			awaited_results.push_back(exp);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
				error_count++;
			end
		endfunction

		// compare one response against the oldest prediction
		function void check_result(rsp_t act);
			rsp_t exp;
			if (awaited_results.size() == 0) begin
				$display("%0t: unexpected response, expected none, actual %h", $time, act);
				error_count++;
				return;
			end
			exp = awaited_results.pop_front();
			compare_field("status", exp.status, act.status);
			compare_field("value_out", exp.value_out, act.value_out);
			compare_field("slot_index", exp.slot_index, act.slot_index);
			compare_field("entry_count", exp.entry_count, act.entry_count);
		endfunction
	endclass

	typedef struct {
		logic [31:0] h;
		logic [31:0] k;
	} key_ref_t;

	logic clk;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic done;
	rsp_t rsp;

	probe_table_model table_sb;
	key_ref_t         known_keys[$];
	int unsigned      cycle_count;

	quadratic_probe_hash_table #(
		.CAPACITY(SLOTS)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// response check first, then note the item taken on the same edge
	always @(posedge clk) begin
		if (arst_n === 1'b1 && table_sb != null) begin
			if (done === 1'b1)
				table_sb.check_result(rsp);
			if (start === 1'b1 && busy === 1'b0)
				table_sb.note_request(req);
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("TB_ERROR");
			$finish;
		end
	end

	// present an item and hold it until the block takes it
	task automatic send_request(input req_t r);
		@(negedge clk);
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
	endtask

	task automatic issue(input logic [1:0] m, input logic [31:0] h, input logic [31:0] k,
			input logic [31:0] v);
		req_t r;
		r.mode     = m;
		r.key_hash = h;
		r.key      = k;
		r.value_in = v;
		send_request(r);
	endtask

	// drive start low for an idle gap whose length is set by n
	task automatic idle_cycles(input int n);
		@(negedge clk);
		start <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// hold off until every predicted response has arrived
	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (table_sb.awaited_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic void remember_key(logic [31:0] h, logic [31:0] k);
		key_ref_t kr;
		kr.h = h;
		kr.k = k;
		known_keys.push_back(kr);
		if (known_keys.size() > POOL_DEPTH)
			void'(known_keys.pop_front());
	endfunction

	// hashes crowd onto a few home slots so that chains form
	function automatic logic [31:0] pick_hash();
		logic [31:0] h;
		h = $urandom;
		if ($urandom_range(0, 3) != 0)
			h[7:0] = 8'($urandom_range(0, 7) * 32);
		return h;
	endfunction

	// mostly requests on keys already inserted, some noise
	function automatic req_t random_request(int w_ins, int w_look, int w_rem);
		req_t     r;
		key_ref_t kr;
		int       roll;
		r.key_hash = pick_hash();
		r.key      = $urandom;
		r.value_in = $urandom;
		roll       = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < 15) begin
			r.mode = 2'($urandom_range(0, 3));
		end else if (roll < w_ins || known_keys.size() == 0) begin
			r.mode = MODE_INSERT;
			remember_key(r.key_hash, r.key);
		end else begin
			if (roll < w_ins + w_look)
				r.mode = MODE_LOOKUP;
			else if (roll < w_ins + w_look + w_rem)
				r.mode = MODE_REMOVE;
			else
				r.mode = MODE_UPDATE;
			kr    = known_keys[$urandom_range(0, known_keys.size() - 1)];
			r.key = kr.k;
			if ($urandom_range(0, 9) != 0)
				r.key_hash = kr.h;
		end
		return r;
	endfunction

	// random items; idling in bursts, switched off every other stretch of 40
	task automatic run_phase(input int count, input int w_ins, input int w_look,
			input int w_rem, input bit idling);
		for (int n = 0; n < count; n++) begin
			send_request(random_request(w_ins, w_look, w_rem));
			if (idling && ((n / 40) % 2 == 0) && $urandom_range(0, 3) == 0)
				idle_cycles($urandom_range(1, 3));
		end
	endtask

	initial begin
		logic [31:0] pile_base;
		logic [31:0] pile_hash;
		logic [31:0] pile_key;
		clk_init: begin
			start       = 1'b0;
			req         = '0;
			arst_n      = 1'b0;
			cycle_count = 0;
		end
		table_sb = new();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, chains, deleted slot reuse, duplicates, misses
		issue(MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		issue(MODE_INSERT, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
		issue(MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		issue(MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
		issue(MODE_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue(MODE_INSERT, 32'h1234_5610, 32'h0000_00AA, 32'h0000_0001);
		issue(MODE_INSERT, 32'h1234_5610, 32'h0000_00BB, 32'h0000_0002);
		issue(MODE_INSERT, 32'h1234_5610, 32'h0000_00AA, 32'h0000_0003);
		issue(MODE_REMOVE, 32'h1234_5610, 32'h0000_00AA, 32'h0000_0000);
		issue(MODE_LOOKUP, 32'h1234_5610, 32'h0000_00AA, 32'h0000_0000);
		issue(MODE_INSERT, 32'h1234_5610, 32'h0000_00CC, 32'h0000_0004);
		issue(MODE_UPDATE, 32'h1234_5610, 32'h0000_00BB, 32'hA5A5_A5A5);
		issue(MODE_LOOKUP, 32'h1234_5610, 32'h0000_00BB, 32'h0000_0000);
		issue(MODE_UPDATE, 32'h1234_5610, 32'h0000_DEAD, 32'h1111_1111);
		issue(MODE_REMOVE, 32'h1234_5610, 32'h0000_DEAD, 32'h0000_0000);
		issue(MODE_LOOKUP, 32'h1234_5612, 32'h0000_00BB, 32'h0000_0000);
		issue(MODE_UPDATE, 32'hFFFF_FFFF, 32'h0000_0000, 32'h5A5A_5A5A);
		issue(MODE_LOOKUP, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
		issue(MODE_REMOVE, 32'h0000_0000, 32'h0000_00BB, 32'h0000_0000);
		issue(MODE_REMOVE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		issue(MODE_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
		issue(MODE_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
		wait_drained();

		// pile-up on one home slot until the probe sequence is exhausted
		pile_base = $urandom;
		for (int n = 0; n < 60; n++) begin
			pile_hash = $urandom;
			pile_hash[7:0] = pile_base[7:0];
			pile_key = $urandom;
			if (n % 10 == 9 && known_keys.size() != 0) begin
				issue(MODE_LOOKUP, known_keys[known_keys.size() - 1].h,
					known_keys[known_keys.size() - 1].k, $urandom);
			end else begin
				issue(MODE_INSERT, pile_hash, pile_key, $urandom);
				remember_key(pile_hash, pile_key);
			end
			if ($urandom_range(0, 3) == 0)
				idle_cycles($urandom_range(1, 3));
		end
		wait_drained();

		// mixed traffic, then heavy removal with reuse of deleted slots
		run_phase(450, 35, 30, 20, 1'b1);
		wait_drained();
		run_phase(150, 20, 30, 50, 1'b1);

		// last stretch back to back
		run_phase(100, 30, 30, 20, 1'b0);

		// drain, then leave room for any stray response
		@(negedge clk);
		start <= 1'b0;
		while (table_sb.awaited_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (table_sb.error_count == 0 && table_sb.awaited_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
